@@ design/dfpca_pkg.sv @@
// Shared constants and types for the calibrated dust-sensor frame parser.
// Used by dust_frame_parser_calibrated_average_top; no dependencies.
package dfpca_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 10;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'hC0;
  localparam logic [7:0] TAIL = 8'hAB;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int GAIN_W      = 16;
  localparam int OFFSET_W    = 15;
  localparam int WORD_W      = 16;
  localparam int COUNT_OUT_W = 4;

  localparam logic [GAIN_W-1:0] UNITY_GAIN   = 16'd256;
  localparam logic [WORD_W-1:0] CLAMP_TENTHS = 16'd9990;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_PM25   = 2'd0,
    REG_OFFSET_PM25 = 2'd1,
    REG_GAIN_PM10   = 2'd2,
    REG_OFFSET_PM10 = 2'd3
  } cfg_reg_t;

  typedef logic [3:0] frame_pos_t;

  localparam frame_pos_t FP_HDR0    = 4'd0;
  localparam frame_pos_t FP_HDR1    = 4'd1;
  localparam frame_pos_t FP_PM25_LO = 4'd2;
  localparam frame_pos_t FP_PM25_HI = 4'd3;
  localparam frame_pos_t FP_PM10_LO = 4'd4;
  localparam frame_pos_t FP_PM10_HI = 4'd5;
  localparam frame_pos_t FP_EXTRA0  = 4'd6;
  localparam frame_pos_t FP_EXTRA1  = 4'd7;
  localparam frame_pos_t FP_CHECK   = 4'd8;
  localparam frame_pos_t FP_TAIL    = 4'd9;

endpackage

@@ design/dfpca_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Self-contained; the top level sizes it through its parameters.
module dfpca_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  // The quotient register starts out holding the dividend and shifts it out MSB first.
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      rem  <= '0;
      quot <= num;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

@@ design/dust_frame_parser_calibrated_average_top.sv @@
// Dust-sensor frame parser with per-channel calibration and a moving average.
// Depends on dfpca_pkg and instantiates two dfpca_div dividers.
//
// Bytes that do not end a frame are taken one per cycle. The tail byte of a
// good frame starts the averaging pass, during which no byte is taken. Its
// steps, in order: calibration (multiply, then offset and clamp), the write of
// the history memory, the read-back of the stored values one entry per cycle
// with a drain of the read pipeline, the start of the dividers, the bit-serial
// division and the load of the output register. The last step is held back
// only while an earlier result still waits in the output register. A finished
// result sits in the output register until it is taken, while later bytes
// keep flowing in. The history memory needs no clearing after reset: only
// entries already written are ever summed.
module dust_frame_parser_calibrated_average_top #(
  parameter int WINDOW_DEPTH = dfpca_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dfpca_pkg::WORD_W-1:0]       pm25_average,
  output logic [dfpca_pkg::WORD_W-1:0]       pm10_average,
  output logic [dfpca_pkg::COUNT_OUT_W-1:0]  sample_count,
  input  logic                               cfg_we,
  input  logic [dfpca_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dfpca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WORD_W = dfpca_pkg::WORD_W;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = WORD_W + CNT_W;
  localparam int PROD_W = WORD_W + dfpca_pkg::GAIN_W;
  localparam int CAL_W  = PROD_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_WRITE,
    S_READ,
    S_DIV,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [dfpca_pkg::GAIN_W-1:0]   gain_pm25;
  logic [dfpca_pkg::GAIN_W-1:0]   gain_pm10;
  logic [dfpca_pkg::OFFSET_W-1:0] offset_pm25;
  logic [dfpca_pkg::OFFSET_W-1:0] offset_pm10;

  // Parser state.
  dfpca_pkg::frame_pos_t frame_position;
  logic [WORD_W-1:0]     pm25_word;
  logic [WORD_W-1:0]     pm10_word;
  logic [7:0]            running_checksum;

  // Ring bookkeeping and the history memory: PM10 in the upper half, PM2.5 in the lower.
  logic [IDX_W-1:0]    write_pointer;
  logic [CNT_W-1:0]    fill_count;
  logic [2*WORD_W-1:0] hist [WINDOW_DEPTH];
  logic [2*WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                rd_en;
  logic [CNT_W-1:0]    rd_issue;
  logic                rd_pend;

  // Datapath registers.
  logic [PROD_W-1:0] prod25;
  logic [PROD_W-1:0] prod10;
  logic [WORD_W-1:0] val25;
  logic [WORD_W-1:0] val10;
  logic [SUM_W-1:0]  sum25;
  logic [SUM_W-1:0]  sum10;

  logic             div_start;
  logic             div25_done;
  logic             div10_done;
  logic [SUM_W-1:0] quot25;
  logic [SUM_W-1:0] quot10;

  logic                         in_fire;
  logic [dfpca_pkg::GAIN_W-1:0] gain25_eff;
  logic [dfpca_pkg::GAIN_W-1:0] gain10_eff;
  logic [WORD_W-1:0]            cal25;
  logic [WORD_W-1:0]            cal10;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // A channel with both gain and offset at zero runs at unity gain.
  assign gain25_eff = (gain_pm25 == '0 && offset_pm25 == '0) ? dfpca_pkg::UNITY_GAIN
                                                             : gain_pm25;
  assign gain10_eff = (gain_pm10 == '0 && offset_pm10 == '0) ? dfpca_pkg::UNITY_GAIN
                                                             : gain_pm10;

  function automatic logic [WORD_W-1:0] clamp_cal(
    input logic [PROD_W-1:0]                 prod,
    input logic [dfpca_pkg::OFFSET_W-1:0]    offset
  );
    logic signed [CAL_W-1:0] v;
    logic signed [CAL_W-1:0] off_q8;
    logic signed [CAL_W-1:0] limit;
    off_q8 = $signed({{(CAL_W-dfpca_pkg::OFFSET_W-8){offset[dfpca_pkg::OFFSET_W-1]}},
                      offset, 8'h00});
    limit  = $signed({{(CAL_W-WORD_W-8){1'b0}}, dfpca_pkg::CLAMP_TENTHS, 8'h00});
    v      = $signed({2'b00, prod}) + off_q8;
    if (v[CAL_W-1]) begin
      clamp_cal = '0;
    end else if (v >= limit) begin
      clamp_cal = dfpca_pkg::CLAMP_TENTHS;
    end else begin
      clamp_cal = v[WORD_W+7:8];
    end
  endfunction

  assign cal25 = clamp_cal(prod25, offset_pm25);
  assign cal10 = clamp_cal(prod10, offset_pm10);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pm25   <= dfpca_pkg::UNITY_GAIN;
      gain_pm10   <= dfpca_pkg::UNITY_GAIN;
      offset_pm25 <= '0;
      offset_pm10 <= '0;
    end else if (cfg_we) begin
      unique case (dfpca_pkg::cfg_reg_t'(cfg_index))
        dfpca_pkg::REG_GAIN_PM25:   gain_pm25   <= cfg_data;
        dfpca_pkg::REG_OFFSET_PM25: offset_pm25 <= cfg_data[dfpca_pkg::OFFSET_W-1:0];
        dfpca_pkg::REG_GAIN_PM10:   gain_pm10   <= cfg_data;
        dfpca_pkg::REG_OFFSET_PM10: offset_pm10 <= cfg_data[dfpca_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      hist[write_pointer] <= {val10, val25};
    end
    if (rd_en) begin
      rd_data <= hist[rd_addr];
    end
  end

  // Reads start only after the write cycle, so a read never overlaps the write
  // of the same entry.
  assign rd_en   = (state == S_READ) && (rd_issue != fill_count);
  assign rd_addr = rd_issue[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_position   <= dfpca_pkg::FP_HDR0;
      pm25_word        <= '0;
      pm10_word        <= '0;
      running_checksum <= '0;
      write_pointer    <= '0;
      fill_count       <= '0;
      rd_pend          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // In S_OUT a taken beat is replaced by the next one instead.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (frame_position)
              dfpca_pkg::FP_HDR0: begin
                frame_position <= (rx_byte == dfpca_pkg::HDR0) ? dfpca_pkg::FP_HDR1
                                                               : dfpca_pkg::FP_HDR0;
              end
              dfpca_pkg::FP_HDR1: begin
                frame_position <= (rx_byte == dfpca_pkg::HDR1) ? dfpca_pkg::FP_PM25_LO
                                                               : dfpca_pkg::FP_HDR0;
              end
              dfpca_pkg::FP_PM25_LO: begin
                pm25_word        <= {8'h00, rx_byte};
                running_checksum <= rx_byte;
                frame_position   <= dfpca_pkg::FP_PM25_HI;
              end
              dfpca_pkg::FP_PM25_HI: begin
                pm25_word[15:8]  <= rx_byte;
                running_checksum <= running_checksum + rx_byte;
                frame_position   <= dfpca_pkg::FP_PM10_LO;
              end
              dfpca_pkg::FP_PM10_LO: begin
                pm10_word        <= {8'h00, rx_byte};
                running_checksum <= running_checksum + rx_byte;
                frame_position   <= dfpca_pkg::FP_PM10_HI;
              end
              dfpca_pkg::FP_PM10_HI: begin
                pm10_word[15:8]  <= rx_byte;
                running_checksum <= running_checksum + rx_byte;
                frame_position   <= dfpca_pkg::FP_EXTRA0;
              end
              dfpca_pkg::FP_EXTRA0: begin
                running_checksum <= running_checksum + rx_byte;
                frame_position   <= dfpca_pkg::FP_EXTRA1;
              end
              dfpca_pkg::FP_EXTRA1: begin
                running_checksum <= running_checksum + rx_byte;
                frame_position   <= dfpca_pkg::FP_CHECK;
              end
              dfpca_pkg::FP_CHECK: begin
                frame_position <= (rx_byte == running_checksum) ? dfpca_pkg::FP_TAIL
                                                                : dfpca_pkg::FP_HDR0;
              end
              dfpca_pkg::FP_TAIL: begin
                frame_position <= dfpca_pkg::FP_HDR0;
                if (rx_byte == dfpca_pkg::TAIL) state <= S_MUL;
              end
              default: frame_position <= dfpca_pkg::FP_HDR0;
            endcase
          end
        end
        S_MUL: begin
          prod25 <= PROD_W'(pm25_word) * PROD_W'(gain25_eff);
          prod10 <= PROD_W'(pm10_word) * PROD_W'(gain10_eff);
          state  <= S_CLAMP;
        end
        S_CLAMP: begin
          // With both gains at zero the raw words are stored without clamping.
          if (gain_pm25 == '0 && gain_pm10 == '0) begin
            val25 <= pm25_word;
            val10 <= pm10_word;
          end else begin
            val25 <= cal25;
            val10 <= cal10;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          write_pointer <= (write_pointer == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                       : write_pointer + 1'b1;
          if (fill_count < CNT_W'(WINDOW_DEPTH)) begin
            fill_count <= fill_count + 1'b1;
          end
          rd_issue <= '0;
          rd_pend  <= 1'b0;
          sum25    <= '0;
          sum10    <= '0;
          state    <= S_READ;
        end
        S_READ: begin
          if (rd_pend) begin
            sum25 <= sum25 + SUM_W'(rd_data[WORD_W-1:0]);
            sum10 <= sum10 + SUM_W'(rd_data[2*WORD_W-1:WORD_W]);
          end
          if (rd_en) begin
            rd_issue <= rd_issue + 1'b1;
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div25_done && div10_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            pm25_average <= quot25[WORD_W-1:0];
            pm10_average <= quot10[WORD_W-1:0];
            sample_count <= dfpca_pkg::COUNT_OUT_W'(fill_count);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Both dividers load at the edge that ends S_DIV and finish together.
  assign div_start = (state == S_DIV);

  dfpca_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div25 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum25),
    .den   (fill_count),
    .done  (div25_done),
    .quot  (quot25)
  );

  dfpca_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum10),
    .den   (fill_count),
    .done  (div10_done),
    .quot  (quot10)
  );

endmodule
